>>> rtl/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg: shared types and constants of the stepper ramp pulse generator
// Holds the opcodes, register indexes, sequencer states and the interface
// structs of the serial divider.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int unsigned DvdW   = 24;
  localparam int unsigned DsrW   = 16;
  localparam int unsigned DivCntW = $clog2(DvdW);

  localparam logic [15:0] SpeedStart     = 16'd10;
  localparam logic [23:0] SpeedFloor     = 24'd10;
  localparam logic [23:0] CircleMinIntvl = 24'd100;
  localparam logic [23:0] IntervalMax    = 24'hFFFFFF;
  localparam logic [23:0] ExpZeroQuot    = 24'd65535;

  typedef enum logic [1:0] {
    OP_LINE   = 2'd0,
    OP_CIRCLE = 2'd1,
    OP_TIMER  = 2'd2,
    OP_STOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_RAMP_EXP  = 2'd0,
    REG_MICROSTEP = 2'd1,
    REG_TIME_FACT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    WH_LINE  = 2'd0,
    WH_LEFT  = 2'd1,
    WH_RIGHT = 2'd2
  } wheel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CDIV,
    ST_PULSE,
    ST_RAMP,
    ST_RDIV,
    ST_RCAP,
    ST_IDIV,
    ST_COUNT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/srpg_div.sv
// ----------------------------------------------------------------------------
// srpg_div: serial restoring divider
// Unsigned 24 by 16 bit division, one quotient bit per cycle; done pulses
// for one cycle with the quotient. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module srpg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srpg_pkg::div_req_t req_i,
  output srpg_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [srpg_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [srpg_pkg::DsrW-1:0]     rem_q, rem_d;
  logic [srpg_pkg::DvdW-1:0]     quo_q, quo_d;
  logic [srpg_pkg::DsrW-1:0]     dsr_q, dsr_d;
  logic [srpg_pkg::DsrW:0]       trial;
  logic [srpg_pkg::DsrW:0]       diff;

  assign trial = {rem_q, quo_q[srpg_pkg::DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = srpg_pkg::DivCntW'(srpg_pkg::DvdW - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // Keep the partial remainder if the divisor does not fit.
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[srpg_pkg::DsrW-1:0];
        quo_d = {quo_q[srpg_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[srpg_pkg::DsrW-1:0];
        quo_d = {quo_q[srpg_pkg::DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/stepper_ramp_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator: two-axis stepper pulse generator
// Trapezoidal or exponential speed ramp, line and circle motions, one
// result transfer for every command transfer.
// ----------------------------------------------------------------------------
// Each command transfer yields exactly one result transfer. A stop, a
// refused start or a timer event while idle goes straight to the result.
// A timer event during a motion, or an accepted start, runs one pulse: a
// ramp step (it divides only on an exponential ramp down) followed by the
// interval division time_factor / speed (skipped for a zero speed), all on
// one shared serial divider that retires one quotient bit per cycle. A
// circle start adds one more division for the initial wheel intervals.
// The command side is not ready while a pulse is computed or a result
// waits to be taken. Speeds are in steps per second, accel is unsigned
// Q8.8, and all ramp results are truncated toward zero. Configuration
// writes take effect at once.
module stepper_ramp_pulse_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Command stream. tdata from bit 0: turn_on_spot, steps_first,
  // steps_second, speed_first, speed_second, accel_in, zero fill.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  // tuser: opcode.
  input  logic [1:0]   s_axis_tuser,
  // Result stream. tdata from bit 0: accepted, pulse_x, pulse_y, dir_x,
  // dir_y, enable_n, next_interval, busy_res, zero fill.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [23:0]  cfg_wdata_i
);

  // Command fields.
  logic               in_turn;
  logic signed [23:0] in_steps1, in_steps2;
  logic [15:0]        in_speed1, in_speed2, in_accel;
  srpg_pkg::opcode_e  in_op;

  assign in_turn   = s_axis_tdata[0];
  assign in_steps1 = s_axis_tdata[24:1];
  assign in_steps2 = s_axis_tdata[48:25];
  assign in_speed1 = s_axis_tdata[64:49];
  assign in_speed2 = s_axis_tdata[80:65];
  assign in_accel  = s_axis_tdata[96:81];
  assign in_op     = srpg_pkg::opcode_e'(s_axis_tuser);

  // Configuration registers.
  logic        ramp_exp_q;
  logic [4:0]  ustep_q;
  logic [23:0] tfact_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_exp_q <= 1'b0;
      ustep_q    <= 5'd4;
      tfact_q    <= 24'd500000;
    end else if (cfg_we_i) begin
      case (srpg_pkg::reg_idx_e'(cfg_addr_i))
        srpg_pkg::REG_RAMP_EXP:  ramp_exp_q <= cfg_wdata_i[0];
        srpg_pkg::REG_MICROSTEP: ustep_q    <= cfg_wdata_i[4:0];
        srpg_pkg::REG_TIME_FACT: tfact_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Motion state.
  srpg_pkg::state_e state_q, state_d;
  srpg_pkg::wheel_e wheel_q;
  logic        moving_q, circle_q, drv_off_q;
  logic [1:0]  dir_q;
  logic [31:0] remain_q, rsc_q;
  logic [15:0] line_spd_q, line_tgt_q, left_spd_q, right_spd_q;
  logic [15:0] left_tgt_q, right_tgt_q, accel_q;
  logic [23:0] left_iv_q, right_iv_q;
  // Per-item working registers.
  logic        acc_q, px_q, py_q, down_q, up_q;
  logic [23:0] iv_q, v_q;

  srpg_pkg::div_req_t div_req;
  srpg_pkg::div_rsp_t div_rsp;

  srpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic in_xfer;
  logic is_start;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_start = (in_op == srpg_pkg::OP_LINE) || (in_op == srpg_pkg::OP_CIRCLE);

  // Step magnitudes; the most negative value maps to 2^23.
  logic [23:0] mag1, mag2;
  logic [24:0] mag_sum;
  logic        pos1, pos2;
  assign mag1    = in_steps1[23] ? 24'(-in_steps1) : in_steps1;
  assign mag2    = in_steps2[23] ? 24'(-in_steps2) : in_steps2;
  assign mag_sum = {1'b0, mag1} + {1'b0, mag2};
  assign pos1    = !in_steps1[23] && (in_steps1 != '0);
  assign pos2    = !in_steps2[23] && (in_steps2 != '0);

  // Speed and target of the wheel being stepped.
  logic [15:0] cur_spd, cur_tgt;
  always_comb begin
    case (wheel_q)
      srpg_pkg::WH_LEFT: begin
        cur_spd = left_spd_q;
        cur_tgt = left_tgt_q;
      end
      srpg_pkg::WH_RIGHT: begin
        cur_spd = right_spd_q;
        cur_tgt = right_tgt_q;
      end
      default: begin
        cur_spd = line_spd_q;
        cur_tgt = line_tgt_q;
      end
    endcase
  end

  // Ramp decision: the ramp down uses the count before this pulse.
  logic        ramp_down, ramp_up;
  logic [23:0] spd_sh, lin_up, lin_dn, lin_diff, exp_up, ramp_v;
  logic [31:0] prod;
  assign ramp_down = remain_q < rsc_q;
  assign ramp_up   = !ramp_down && (cur_spd < cur_tgt);
  assign spd_sh    = {cur_spd, 8'd0};
  assign lin_up    = {8'd0, cur_spd} + {16'd0, accel_q[15:8]};
  assign lin_diff  = spd_sh - {8'd0, accel_q};
  assign lin_dn    = (spd_sh > {8'd0, accel_q}) ? {8'd0, lin_diff[23:8]} : '0;
  assign prod      = cur_spd * accel_q;
  assign exp_up    = prod[31:8];

  always_comb begin
    if (ramp_down) begin
      ramp_v = ramp_exp_q ? srpg_pkg::ExpZeroQuot : lin_dn;
    end else if (ramp_up) begin
      ramp_v = ramp_exp_q ? exp_up : lin_up;
    end else begin
      ramp_v = {8'd0, cur_spd};
    end
  end

  logic exp_div;
  assign exp_div = ramp_down && ramp_exp_q && (accel_q != '0);

  // Floor on the way down, then cap at the target.
  logic [23:0] v_floor;
  logic [15:0] new_spd;
  assign v_floor = (down_q && (v_q < srpg_pkg::SpeedFloor)) ? srpg_pkg::SpeedFloor : v_q;
  assign new_spd = (v_floor > {8'd0, cur_tgt}) ? cur_tgt : v_floor[15:0];

  // Circle: the wheel with the shorter pending interval steps.
  logic        on_y;
  logic [23:0] circ_iv;
  assign on_y    = right_iv_q < left_iv_q;
  assign circ_iv = on_y ? right_iv_q : left_iv_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srpg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (((in_op == srpg_pkg::OP_TIMER) || (in_op == srpg_pkg::OP_LINE)) &&
              moving_q == (in_op == srpg_pkg::OP_TIMER)) begin
            state_d = srpg_pkg::ST_PULSE;
          end else if (in_op == srpg_pkg::OP_CIRCLE && !moving_q) begin
            state_d = srpg_pkg::ST_CDIV;
          end else begin
            state_d = srpg_pkg::ST_OUT;
          end
        end
      end
      srpg_pkg::ST_CDIV:  if (div_rsp.done) state_d = srpg_pkg::ST_PULSE;
      srpg_pkg::ST_PULSE: state_d = srpg_pkg::ST_RAMP;
      srpg_pkg::ST_RAMP:  state_d = exp_div ? srpg_pkg::ST_RDIV : srpg_pkg::ST_RCAP;
      srpg_pkg::ST_RDIV:  if (div_rsp.done) state_d = srpg_pkg::ST_RCAP;
      srpg_pkg::ST_RCAP:  state_d = (new_spd == '0) ? srpg_pkg::ST_COUNT : srpg_pkg::ST_IDIV;
      srpg_pkg::ST_IDIV:  if (div_rsp.done) state_d = srpg_pkg::ST_COUNT;
      srpg_pkg::ST_COUNT: state_d = srpg_pkg::ST_OUT;
      srpg_pkg::ST_OUT:   if (m_axis_tready) state_d = srpg_pkg::ST_IDLE;
      default:            state_d = srpg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes and divider requests.
  always_comb begin
    s_axis_tready    = 1'b0;
    m_axis_tvalid    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {8'd0, spd_sh[23:8]};
    div_req.divisor  = accel_q;
    case (state_q)
      srpg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        // Both wheels start at the same speed, so one division serves both.
        div_req.start    = in_xfer && (in_op == srpg_pkg::OP_CIRCLE) && !moving_q;
        div_req.dividend = tfact_q;
        div_req.divisor  = srpg_pkg::SpeedStart;
      end
      srpg_pkg::ST_RAMP: begin
        div_req.start    = exp_div;
        div_req.dividend = spd_sh;
        div_req.divisor  = accel_q;
      end
      srpg_pkg::ST_RCAP: begin
        div_req.start    = (new_spd != '0);
        div_req.dividend = tfact_q;
        div_req.divisor  = new_spd;
      end
      srpg_pkg::ST_OUT: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srpg_pkg::ST_IDLE;
      wheel_q     <= srpg_pkg::WH_LINE;
      moving_q    <= 1'b0;
      circle_q    <= 1'b0;
      drv_off_q   <= 1'b1;
      dir_q       <= '0;
      remain_q    <= '0;
      rsc_q       <= '0;
      line_spd_q  <= srpg_pkg::SpeedStart;
      line_tgt_q  <= 16'd100;
      left_spd_q  <= srpg_pkg::SpeedStart;
      right_spd_q <= srpg_pkg::SpeedStart;
      left_tgt_q  <= 16'd10;
      right_tgt_q <= 16'd10;
      left_iv_q   <= 24'd10;
      right_iv_q  <= 24'd10;
      accel_q     <= 16'd1536;
    end else begin
      state_q <= state_d;
      case (state_q)
        srpg_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (is_start && !moving_q) begin
              moving_q  <= 1'b1;
              drv_off_q <= 1'b0;
              rsc_q     <= '0;
              if (in_op == srpg_pkg::OP_LINE) begin
                circle_q   <= 1'b0;
                wheel_q    <= srpg_pkg::WH_LINE;
                if (in_steps1[23]) begin
                  dir_q <= in_turn ? 2'b00 : 2'b10;
                end else if (pos1) begin
                  dir_q <= in_turn ? 2'b11 : 2'b01;
                end
                remain_q   <= 32'(mag1) * 32'(ustep_q);
                line_spd_q <= srpg_pkg::SpeedStart;
                line_tgt_q <= in_speed1;
                accel_q    <= in_accel;
              end else begin
                circle_q    <= 1'b1;
                left_spd_q  <= srpg_pkg::SpeedStart;
                right_spd_q <= srpg_pkg::SpeedStart;
                left_tgt_q  <= in_speed1;
                right_tgt_q <= in_speed2;
                dir_q       <= {!pos2, pos1};
                remain_q    <= 32'(mag_sum) * 32'(ustep_q);
              end
            end else if (in_op == srpg_pkg::OP_STOP) begin
              drv_off_q <= 1'b1;
              moving_q  <= 1'b0;
              remain_q  <= '0;
            end else if (in_op == srpg_pkg::OP_TIMER && moving_q && !circle_q) begin
              wheel_q <= srpg_pkg::WH_LINE;
            end
          end
        end
        srpg_pkg::ST_CDIV: begin
          if (div_rsp.done) begin
            left_iv_q  <= div_rsp.quotient;
            right_iv_q <= div_rsp.quotient;
          end
        end
        srpg_pkg::ST_PULSE: begin
          if (circle_q) begin
            if (on_y) begin
              wheel_q   <= srpg_pkg::WH_RIGHT;
              left_iv_q <= left_iv_q - right_iv_q;
            end else begin
              wheel_q    <= srpg_pkg::WH_LEFT;
              right_iv_q <= right_iv_q - left_iv_q;
            end
          end
        end
        srpg_pkg::ST_RCAP: begin
          case (wheel_q)
            srpg_pkg::WH_LEFT:  left_spd_q  <= new_spd;
            srpg_pkg::WH_RIGHT: right_spd_q <= new_spd;
            default:            line_spd_q  <= new_spd;
          endcase
          if (up_q) rsc_q <= rsc_q + 32'd1;
          if (new_spd == '0) begin
            case (wheel_q)
              srpg_pkg::WH_LEFT:  left_iv_q  <= srpg_pkg::IntervalMax;
              srpg_pkg::WH_RIGHT: right_iv_q <= srpg_pkg::IntervalMax;
              default: ;
            endcase
          end
        end
        srpg_pkg::ST_IDIV: begin
          if (div_rsp.done) begin
            case (wheel_q)
              srpg_pkg::WH_LEFT:  left_iv_q  <= div_rsp.quotient;
              srpg_pkg::WH_RIGHT: right_iv_q <= div_rsp.quotient;
              default: ;
            endcase
          end
        end
        srpg_pkg::ST_COUNT: begin
          // The pulse that finds one step or fewer left ends the motion.
          if (remain_q <= 32'd1) begin
            drv_off_q <= 1'b1;
            moving_q  <= 1'b0;
            remain_q  <= '0;
          end else begin
            remain_q <= remain_q - 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      srpg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          acc_q <= is_start && !moving_q;
          px_q  <= 1'b0;
          py_q  <= 1'b0;
          iv_q  <= '0;
        end
      end
      srpg_pkg::ST_PULSE: begin
        if (circle_q) begin
          px_q <= !on_y;
          py_q <= on_y;
          iv_q <= (circ_iv < srpg_pkg::CircleMinIntvl) ? srpg_pkg::CircleMinIntvl : circ_iv;
        end else begin
          px_q <= 1'b1;
          py_q <= 1'b1;
        end
      end
      srpg_pkg::ST_RAMP: begin
        down_q <= ramp_down;
        up_q   <= ramp_up;
        v_q    <= ramp_v;
      end
      srpg_pkg::ST_RDIV: begin
        if (div_rsp.done) v_q <= div_rsp.quotient;
      end
      srpg_pkg::ST_RCAP: begin
        if (new_spd == '0 && !circle_q) iv_q <= srpg_pkg::IntervalMax;
      end
      srpg_pkg::ST_IDIV: begin
        if (div_rsp.done && !circle_q) iv_q <= div_rsp.quotient;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {1'b0, moving_q, (moving_q ? iv_q : 24'd0), drv_off_q,
                         dir_q[1], dir_q[0], py_q, px_q, acc_q};

  // Checks.
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> (remain_q == '0))
    else $error("steps left while no motion runs");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("command taken while a result waits");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[30]) |-> (m_axis_tdata[29:6] == '0 && m_axis_tdata[5]))
    else $error("idle result reports an interval or enabled drivers");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stepper ramp pulse generator
// A driver feeds commands from a pending queue with random gaps. A monitor
// takes results under random back-pressure and compares each field with
// the output of a cycle-free model of the block. The model is updated on
// every accepted command transfer. Configuration changes only while the
// block is idle, between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WatchdogLimit = 20000;

  // One command as it travels on the command stream.
  typedef struct {
    srpg_pkg::opcode_e op;
    logic              turn;
    logic [23:0]       steps_a;
    logic [23:0]       steps_b;
    logic [15:0]       speed_a;
    logic [15:0]       speed_b;
    logic [15:0]       accel;
  } command_t;

  // One result as the block reports it.
  typedef struct packed {
    logic        accepted;
    logic        pulse_x;
    logic        pulse_y;
    logic        dir_x;
    logic        dir_y;
    logic        enable_n;
    logic [23:0] interval;
    logic        busy;
  } pulse_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_addr_i;
  logic [23:0]  cfg_wdata_i;

  command_t      pending_cmds[$];
  pulse_result_t expected_results[$];
  int            error_count;
  int            results_seen;
  int            idle_cycles;
  bit            quiet_mode;
  int            send_gap;
  int            recv_gap;
  int            long_hold;
  bit            long_hold_done;

  // Copy of the configuration registers.
  logic        m_exp;
  logic [4:0]  m_micro;
  logic [23:0] m_tfact;

  // Copy of the motion state.
  logic        m_moving;
  logic        m_circle;
  logic [31:0] m_remaining;
  logic [31:0] m_ramp_cnt;
  logic [31:0] m_line_speed, m_line_target;
  logic [31:0] m_left_speed, m_right_speed, m_left_target, m_right_target;
  logic [31:0] m_left_intvl, m_right_intvl;
  logic [31:0] m_accel;
  logic [1:0]  m_dirs;
  logic        m_drivers_off;

  stepper_ramp_pulse_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Interval for a given speed; a zero speed gives the longest interval.
  function automatic logic [31:0] speed_to_interval(logic [31:0] speed);
    if (speed == 0) return 32'hFFFFFF;
    return (m_tfact / speed) & 32'hFFFFFF;
  endfunction

  // One ramp step: down once the remaining count drops below the number of
  // ramp-up steps, up while below target, then capped at the target.
  function automatic logic [31:0] next_speed(logic [31:0] speed, logic [31:0] target);
    logic [63:0] v;
    logic [63:0] scaled;
    v = {32'd0, speed};
    scaled = {32'd0, speed} << 8;
    if (m_remaining < m_ramp_cnt) begin
      if (!m_exp) v = (scaled > m_accel) ? ((scaled - m_accel) >> 8) : 64'd0;
      else v = (m_accel != 0) ? (scaled / m_accel) : 64'd65535;
      if (v < 64'd10) v = 64'd10;
    end else if (speed < target) begin
      if (!m_exp) v = (scaled + m_accel) >> 8;
      else v = ({32'd0, speed} * m_accel) >> 8;
      m_ramp_cnt = m_ramp_cnt + 32'd1;
    end
    if (v > {32'd0, target}) v = {32'd0, target};
    return v[31:0];
  endfunction

  function automatic void count_step();
    if (m_remaining <= 1) begin
      m_drivers_off = 1'b1;
      m_moving = 1'b0;
      m_remaining = '0;
    end else begin
      m_remaining = m_remaining - 32'd1;
    end
  endfunction

  function automatic logic [31:0] magnitude24(logic [23:0] raw);
    if (raw[23]) return 32'h1000000 - {8'd0, raw};
    return {8'd0, raw};
  endfunction

  function automatic bit positive24(logic [23:0] raw);
    return !raw[23] && raw != '0;
  endfunction

  function automatic logic [31:0] line_step();
    logic [31:0] iv;
    m_line_speed = next_speed(m_line_speed, m_line_target);
    iv = speed_to_interval(m_line_speed);
    count_step();
    return iv;
  endfunction

  // The wheel with the shorter pending interval steps; ties go to the left.
  function automatic logic [31:0] circle_step(output bit on_right);
    logic [31:0] iv;
    if (m_right_intvl < m_left_intvl) begin
      on_right = 1'b1;
      iv = m_right_intvl;
      m_left_intvl = m_left_intvl - m_right_intvl;
      m_right_speed = next_speed(m_right_speed, m_right_target);
      m_right_intvl = speed_to_interval(m_right_speed);
    end else begin
      on_right = 1'b0;
      iv = m_left_intvl;
      m_right_intvl = m_right_intvl - m_left_intvl;
      m_left_speed = next_speed(m_left_speed, m_left_target);
      m_left_intvl = speed_to_interval(m_left_speed);
    end
    if (iv < 32'd100) iv = 32'd100;
    count_step();
    return iv;
  endfunction

  function automatic pulse_result_t predict_pulse(command_t c);
    pulse_result_t r;
    logic [31:0]   iv;
    bit            on_right;
    r = '0;
    iv = '0;
    on_right = 1'b0;
    if (c.op == srpg_pkg::OP_LINE || c.op == srpg_pkg::OP_CIRCLE) begin
      if (!m_moving) begin
        r.accepted = 1'b1;
        m_moving = 1'b1;
        m_drivers_off = 1'b0;
        m_ramp_cnt = '0;
        if (c.op == srpg_pkg::OP_LINE) begin
          m_circle = 1'b0;
          // Zero steps leave the direction pins as they were.
          if (c.steps_a[23]) m_dirs = c.turn ? 2'd0 : 2'd2;
          else if (c.steps_a != '0) m_dirs = c.turn ? 2'd3 : 2'd1;
          m_remaining = magnitude24(c.steps_a) * {27'd0, m_micro};
          m_line_speed = 32'd10;
          m_line_target = {16'd0, c.speed_a};
          m_accel = {16'd0, c.accel};
          iv = line_step();
          r.pulse_x = 1'b1;
          r.pulse_y = 1'b1;
        end else begin
          m_circle = 1'b1;
          m_right_speed = 32'd10;
          m_right_target = {16'd0, c.speed_b};
          m_left_speed = 32'd10;
          m_left_target = {16'd0, c.speed_a};
          m_right_intvl = speed_to_interval(m_right_speed);
          m_left_intvl = speed_to_interval(m_left_speed);
          m_dirs = {!positive24(c.steps_b), positive24(c.steps_a)};
          m_remaining = (magnitude24(c.steps_a) + magnitude24(c.steps_b)) *
                        {27'd0, m_micro};
          iv = circle_step(on_right);
          r.pulse_x = !on_right;
          r.pulse_y = on_right;
        end
      end
    end else if (c.op == srpg_pkg::OP_TIMER) begin
      // A timer event while idle changes nothing.
      if (m_moving) begin
        if (m_circle) begin
          iv = circle_step(on_right);
          r.pulse_x = !on_right;
          r.pulse_y = on_right;
        end else begin
          iv = line_step();
          r.pulse_x = 1'b1;
          r.pulse_y = 1'b1;
        end
      end
    end else begin
      m_drivers_off = 1'b1;
      m_moving = 1'b0;
      m_remaining = '0;
    end
    r.dir_x = m_dirs[0];
    r.dir_y = m_dirs[1];
    r.enable_n = m_drivers_off;
    r.interval = m_moving ? iv[23:0] : 24'd0;
    r.busy = m_moving;
    return r;
  endfunction

  // Command driver: takes items from the pending queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    command_t c;
    logic     next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        c.op      = srpg_pkg::opcode_e'(s_axis_tuser);
        c.turn    = s_axis_tdata[0];
        c.steps_a = s_axis_tdata[24:1];
        c.steps_b = s_axis_tdata[48:25];
        c.speed_a = s_axis_tdata[64:49];
        c.speed_b = s_axis_tdata[80:65];
        c.accel   = s_axis_tdata[96:81];
        expected_results.push_back(predict_pulse(c));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            send_gap <= int'($urandom_range(1, 15));
          end else begin
            c = pending_cmds.pop_front();
            s_axis_tdata <= {7'd0, c.accel, c.speed_b, c.speed_a, c.steps_b, c.steps_a,
                             c.turn};
            s_axis_tuser <= c.op;
            next_valid = 1'b1;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_result_t got;
    pulse_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted = m_axis_tdata[0];
        got.pulse_x  = m_axis_tdata[1];
        got.pulse_y  = m_axis_tdata[2];
        got.dir_x    = m_axis_tdata[3];
        got.dir_y    = m_axis_tdata[4];
        got.enable_n = m_axis_tdata[5];
        got.interval = m_axis_tdata[29:6];
        got.busy     = m_axis_tdata[30];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected acc=%b px=%b py=%b dx=%b dy=%b en_n=%b %s",
                     $time, want.accepted, want.pulse_x, want.pulse_y, want.dir_x,
                     want.dir_y, want.enable_n, $sformatf("iv=%0d busy=%b",
                     want.interval, want.busy));
            $display("%0t: mismatch, actual   acc=%b px=%b py=%b dx=%b dy=%b en_n=%b %s",
                     $time, got.accepted, got.pulse_x, got.pulse_y, got.dir_x,
                     got.dir_y, got.enable_n, $sformatf("iv=%0d busy=%b",
                     got.interval, got.busy));
            error_count++;
          end
        end
      end
      // One long hold-off lets the block fill up and stall its command side.
      if (!long_hold_done && results_seen == 300) begin
        long_hold_done <= 1'b1;
        long_hold <= 400;
        m_axis_tready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        recv_gap <= int'($urandom_range(1, 15));
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic command_t make_cmd(srpg_pkg::opcode_e op, logic turn, logic [23:0] sa,
                                        logic [23:0] sb, logic [15:0] pa, logic [15:0] pb,
                                        logic [15:0] acc);
    command_t c;
    c.op = op;
    c.turn = turn;
    c.steps_a = sa;
    c.steps_b = sb;
    c.speed_a = pa;
    c.speed_b = pb;
    c.accel = acc;
    return c;
  endfunction

  // A command whose fields are all zero.
  function automatic command_t plain_cmd(srpg_pkg::opcode_e op);
    return make_cmd(op, 1'b0, '0, '0, '0, '0, '0);
  endfunction

  // A command whose fields are all random.
  function automatic command_t noise_cmd(srpg_pkg::opcode_e op);
    return make_cmd(op, 1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [15:0] random_speed();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 60));
      1: return 16'($urandom_range(1, 2000));
      2: return 16'($urandom);
      default: return 16'($urandom_range(61000, 65535));
    endcase
  endfunction

  function automatic logic [23:0] random_steps();
    logic [23:0] n;
    n = 24'($urandom_range(0, 6));
    if ($urandom_range(0, 1) != 0) n = -n;
    return n;
  endfunction

  function automatic logic [15:0] random_accel();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 300));
      1: return 16'($urandom_range(200, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // A motion: a start with random content, a run of timer events, and
  // now and then a stop, a refused start or a huge step count.
  task automatic queue_motion();
    int          ticks;
    logic [23:0] sa;
    logic [23:0] sb;
    sa = random_steps();
    sb = random_steps();
    if ($urandom_range(0, 15) == 0) begin
      sa = 24'($urandom);
      sb = 24'($urandom);
    end
    if ($urandom_range(0, 1) != 0)
      pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'($urandom_range(0, 1)), sa,
                                      24'($urandom), random_speed(), 16'($urandom),
                                      random_accel()));
    else
      pending_cmds.push_back(make_cmd(srpg_pkg::OP_CIRCLE, 1'($urandom), sa, sb,
                                      random_speed(), random_speed(), 16'($urandom)));
    ticks = int'($urandom_range(1, 40));
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0)
        pending_cmds.push_back(noise_cmd(srpg_pkg::opcode_e'($urandom_range(0, 1))));
      else
        pending_cmds.push_back(noise_cmd(srpg_pkg::OP_TIMER));
    end
    if (sa > 24'd100 || $urandom_range(0, 2) == 0)
      pending_cmds.push_back(noise_cmd(srpg_pkg::OP_STOP));
  endtask

  // The sender holds back until every result is in, then lets the block settle.
  task automatic wait_idle();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_config(logic rexp, logic [4:0] micro, logic [23:0] tfact);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= srpg_pkg::REG_RAMP_EXP;
    cfg_wdata_i <= {23'd0, rexp};
    m_exp = rexp;
    @(posedge clk_i);
    cfg_addr_i <= srpg_pkg::REG_MICROSTEP;
    cfg_wdata_i <= {19'd0, micro};
    m_micro = micro;
    @(posedge clk_i);
    cfg_addr_i <= srpg_pkg::REG_TIME_FACT;
    cfg_wdata_i <= tfact;
    m_tfact = tfact;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    error_count = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet_mode = 1'b0;
    long_hold_done = 1'b0;
    m_exp = 1'b0;
    m_micro = 5'd4;
    m_tfact = 24'd500000;
    m_moving = 1'b0;
    m_circle = 1'b0;
    m_remaining = '0;
    m_ramp_cnt = '0;
    m_line_speed = 32'd10;
    m_line_target = 32'd100;
    m_left_speed = 32'd10;
    m_right_speed = 32'd10;
    m_left_target = 32'd10;
    m_right_target = 32'd10;
    m_left_intvl = 32'd10;
    m_right_intvl = 32'd10;
    m_accel = 32'd1536;
    m_dirs = '0;
    m_drivers_off = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: timer while idle, extremes, refusal,
    // zero steps, zero speed, circle directions, stop.
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'b0, 24'd0, '0, 16'd100, '0,
                                    16'd256));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'b1, 24'h7FFFFF, 24'hFFFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_TIMER, 1'b1, '1, '1, '1, '1, '1));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_CIRCLE, 1'b1, 24'd5, 24'd5, 16'd5, 16'd5,
                                    '0));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'b0, 24'h800000, '0, 16'd0, '0,
                                    16'd0));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_CIRCLE, 1'b0, 24'd3, 24'hFFFFFD, 16'd1,
                                    16'hFFFF, '0));
    repeat (4) pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_CIRCLE, 1'b0, 24'h800000, 24'd0, 16'd0,
                                    16'd0, '0));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
    wait_idle();

    // Exponential ramp, zero accel on ramp down, and a one-microstep run.
    write_config(1'b1, 5'd1, 24'd1);
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'b0, 24'd4, '0, 16'd400, '0,
                                    16'd0));
    repeat (5) pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(make_cmd(srpg_pkg::OP_LINE, 1'b1, 24'hFFFFF0, '0, 16'd50, '0,
                                    16'd128));
    repeat (4) pending_cmds.push_back(plain_cmd(srpg_pkg::OP_TIMER));
    pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
    wait_idle();

    // Random phases over several settings, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_config(1'b0, 5'd16, 24'hFFFFFF);
        1: write_config(1'b1, 5'd16, 24'($urandom_range(1000, 16777215)));
        2: write_config(1'b0, 5'd1, 24'($urandom_range(1, 5000)));
        3: write_config(1'b1, 5'($urandom_range(1, 16)), 24'($urandom));
        4: write_config(1'b0, 5'($urandom_range(1, 16)), 24'd500000);
        default: begin
          write_config(1'b1, 5'd4, 24'($urandom));
          quiet_mode = 1'b1;
        end
      endcase
      while (pending_cmds.size() < 280) queue_motion();
      pending_cmds.push_back(plain_cmd(srpg_pkg::OP_STOP));
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
